// ----- rtl/fmpc_pkg.sv -----
// Package for the flashlight mode and pattern controller.
// Holds the payload, state and config types, the codes and the pattern tables.
// No dependencies.
package fmpc_pkg;

	localparam int unsigned MODE_W   = 4;
	localparam int unsigned LEVEL_W  = 8;
	localparam int unsigned DUR_W    = 11;
	localparam int unsigned RPT_W    = 7;
	localparam int unsigned HOLD_W   = 10;
	localparam int unsigned GAUGES   = 5;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [MODE_W-1:0] MODE_LAST         = 4'd14;
	localparam logic [MODE_W-1:0] MODE_STEP_DOWN    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_SOLID_LAST   = 4'd4;
	localparam logic [MODE_W-1:0] MODE_BEACON_FIRST = 4'd5;
	localparam logic [MODE_W-1:0] MODE_BEACON_LAST  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_HEART        = 4'd8;
	localparam logic [MODE_W-1:0] MODE_STROBE_FIRST = 4'd9;
	localparam logic [MODE_W-1:0] MODE_STROBE_LAST  = 4'd11;
	localparam logic [MODE_W-1:0] MODE_SWEEP_A      = 4'd12;
	localparam logic [MODE_W-1:0] MODE_SWEEP_B      = 4'd13;
	localparam logic [MODE_W-1:0] MODE_GAUGE        = 4'd14;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_MED = 8'd37;
	localparam logic [HOLD_W-1:0]  HOLD_MS   = 10'd1000;
	localparam logic [2:0]         LOW_LIMIT = 3'd4;

	typedef enum logic [1:0] {
		CMD_BOOT = 2'd0,
		CMD_TICK = 2'd1,
		CMD_ADC  = 2'd2
	} fmpc_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_TH   = 3'd0,
		REG_CRIT_TH  = 3'd1,
		REG_GAUGE_0  = 3'd2,
		REG_GAUGE_25 = 3'd3,
		REG_GAUGE_50 = 3'd4,
		REG_GAUGE_75 = 3'd5,
		REG_GAUGE_100 = 3'd6
	} fmpc_reg_t;

	typedef struct packed {
		logic [1:0] command;
		logic       short_press;
		logic [7:0] adc_value;
	} fmpc_req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] pwm_level;
		logic               phase_correct;
		logic [MODE_W-1:0]  mode_index;
		logic               powered_off;
	} fmpc_rsp_t;

	typedef struct packed {
		logic [7:0]                low_th;
		logic [7:0]                crit_th;
		logic [GAUGES-1:0][7:0]    gauge;
	} fmpc_cfg_t;

	localparam fmpc_cfg_t CFG_RESET = '{
		low_th:  8'd123,
		crit_th: 8'd113,
		gauge:   {8'd185, 8'd175, 8'd164, 8'd154, 8'd139}
	};

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [MODE_W-1:0]  saved;
		logic [1:0]         phase;
		logic [DUR_W-1:0]   ms_left;
		logic [RPT_W-1:0]   rpt;
		logic [2:0]         low_cnt;
		logic [7:0]         volt;
		logic [2:0]         blinks;
		logic [HOLD_W-1:0]  hold;
		logic [LEVEL_W-1:0] level;
		logic               pc;
		logic               off;
	} fmpc_state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [DUR_W-1:0]   dur;
	} fmpc_phase_t;

	function automatic logic [LEVEL_W-1:0] mode_level(input logic [MODE_W-1:0] m);
		logic [LEVEL_W-1:0] r;
		case (m)
			4'd0:    r = 8'd4;
			4'd1:    r = 8'd14;
			4'd2:    r = 8'd37;
			4'd3:    r = 8'd110;
			4'd4:    r = 8'd255;
			4'd5:    r = 8'd4;
			4'd6:    r = 8'd14;
			4'd7:    r = 8'd37;
			4'd8:    r = 8'd255;
			4'd9:    r = 8'd82;
			4'd10:   r = 8'd41;
			4'd11:   r = 8'd15;
			4'd12:   r = 8'd255;
			4'd13:   r = 8'd255;
			4'd14:   r = 8'd37;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// level and duration of phase p of mode m
	function automatic fmpc_phase_t load_phase(input logic [MODE_W-1:0] m,
			input logic [1:0] p, input logic [RPT_W-1:0] rc);
		fmpc_phase_t r;
		logic [RPT_W-1:0] s;
		r.level = '0;
		r.dur   = 11'd1;
		s       = '0;
		case (m) inside
			[MODE_BEACON_FIRST:MODE_BEACON_LAST]: begin
				if (p == 2'd0) begin
					r.level = mode_level(MODE_W'(m - 4'd3));
					r.dur   = 11'd5;
				end else begin
					r.level = mode_level(m);
					r.dur   = (rc >= 7'd3) ? 11'd785 : 11'd65;
				end
			end
			MODE_HEART: begin
				if (!p[0]) begin
					r.level = LEVEL_MAX;
				end else begin
					r.dur = (p == 2'd1) ? 11'd249 : 11'd749;
				end
			end
			[MODE_STROBE_FIRST:MODE_STROBE_LAST]: begin
				if (p == 2'd0) r.level = LEVEL_MAX;
				else r.dur = {3'b000, mode_level(m)};
			end
			MODE_SWEEP_A: begin
				if (p == 2'd0) begin
					r.level = LEVEL_MAX;
				end else begin
					s     = (rc < 7'd33) ? rc : 7'd66 - rc;
					r.dur = {3'b000, 7'(s + 7'd27), 1'b0};
				end
			end
			MODE_SWEEP_B: begin
				if (p == 2'd0) begin
					r.level = LEVEL_MAX;
				end else begin
					s     = (rc < 7'd50) ? rc : 7'd100 - rc;
					r.dur = {4'b0000, s} + 11'd9;
				end
			end
			MODE_GAUGE: begin
				if (p == 2'd1) begin
					r.level = LEVEL_MED;
					r.dur   = 11'd100;
				end else if (p == 2'd2) begin
					r.dur = 11'd400;
				end else begin
					r.dur = 11'd1000;
				end
			end
			default: begin
				r.level = (m <= MODE_SOLID_LAST) ? mode_level(m) : mode_level(4'd0);
				r.dur   = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/fmpc_step.sv -----
// Next-state logic of the flashlight controller for one event.
// Pure combinational; depends on fmpc_pkg.
module fmpc_step import fmpc_pkg::*; (
	input  fmpc_state_t st,
	input  fmpc_cfg_t   cfg,
	input  fmpc_req_t   req,
	output fmpc_state_t nx
);

	logic [MODE_W:0]    inc_mode;
	logic [MODE_W-1:0]  boot_mode;
	logic [MODE_W-1:0]  start_mode;
	fmpc_phase_t        ph_start;
	fmpc_phase_t        ph_adv;
	logic [2:0]         gauge_cnt;
	logic [2:0]         blink_dec;
	logic [7:0]         th;
	logic [2:0]         cnt_nx;
	logic [1:0]         p_nx;
	logic [RPT_W-1:0]   rpt_last;
	logic               load_en;

	assign inc_mode   = {1'b0, st.saved} + 5'd1;
	assign boot_mode  = !req.short_press ? '0 :
		(inc_mode > {1'b0, MODE_LAST}) ? '0 : inc_mode[MODE_W-1:0];
	assign start_mode = (req.command == CMD_BOOT) ? boot_mode : MODE_STEP_DOWN;
	assign ph_start   = load_phase(start_mode, 2'd0, '0);
	assign th         = (st.mode == '0) ? cfg.crit_th : cfg.low_th;
	assign blink_dec  = (st.blinks == '0) ? '0 : st.blinks - 3'd1;
	assign rpt_last   = (st.mode == MODE_SWEEP_A) ? 7'd65 : 7'd99;

	always_comb begin
		gauge_cnt = '0;
		for (int i = 0; i < GAUGES; i++) begin
			gauge_cnt = gauge_cnt + {2'b00, st.volt > cfg.gauge[i]};
		end
	end

	always_comb begin
		nx      = st;
		p_nx    = st.phase;
		load_en = 1'b1;
		cnt_nx  = '0;
		ph_adv  = '0;
		case (req.command)
			CMD_BOOT: begin
				nx.mode    = boot_mode;
				nx.saved   = boot_mode;
				nx.pc      = (boot_mode == '0);
				nx.off     = 1'b0;
				nx.low_cnt = '0;
				nx.hold    = '0;
				nx.phase   = '0;
				nx.rpt     = '0;
				nx.blinks  = '0;
				nx.level   = ph_start.level;
				nx.ms_left = ph_start.dur;
			end
			CMD_TICK: begin
				if (!st.off) begin
					if (st.hold != '0) nx.hold = st.hold - 10'd1;
					if (st.mode > MODE_SOLID_LAST) begin
						if (st.ms_left > 11'd1) begin
							nx.ms_left = st.ms_left - 11'd1;
						end else begin
							case (st.mode) inside
								[MODE_BEACON_FIRST:MODE_BEACON_LAST]: begin
									if (st.phase == 2'd0) begin
										p_nx = 2'd1;
									end else begin
										nx.rpt = (st.rpt >= 7'd3) ? '0 : st.rpt + 7'd1;
										p_nx   = 2'd0;
									end
								end
								MODE_HEART: p_nx = st.phase + 2'd1;
								[MODE_STROBE_FIRST:MODE_STROBE_LAST]:
									p_nx = (st.phase == 2'd0) ? 2'd1 : 2'd0;
								MODE_SWEEP_A, MODE_SWEEP_B: begin
									if (st.phase == 2'd0) begin
										p_nx = 2'd1;
									end else begin
										nx.rpt = (st.rpt >= rpt_last) ? '0 : st.rpt + 7'd1;
										p_nx   = 2'd0;
									end
								end
								MODE_GAUGE: begin
									case (st.phase)
										2'd0: begin
											nx.blinks = gauge_cnt;
											p_nx      = (gauge_cnt != '0) ? 2'd1 : 2'd3;
										end
										2'd1: p_nx = 2'd2;
										2'd2: begin
											nx.blinks = blink_dec;
											p_nx      = (blink_dec != '0) ? 2'd1 : 2'd3;
										end
										default: p_nx = 2'd0;
									endcase
								end
								default: load_en = 1'b0;
							endcase
							if (load_en) begin
								ph_adv     = load_phase(st.mode, p_nx, nx.rpt);
								nx.phase   = p_nx;
								nx.level   = ph_adv.level;
								nx.ms_left = ph_adv.dur;
							end
						end
					end
				end
			end
			CMD_ADC: begin
				if (!st.off) begin
					nx.volt = req.adc_value;
					if (st.hold == '0) begin
						cnt_nx     = (req.adc_value < th) ? st.low_cnt + 3'd1 : '0;
						nx.low_cnt = cnt_nx;
						if (cnt_nx >= LOW_LIMIT) begin
							if (st.mode > MODE_STEP_DOWN) begin
								nx.mode    = MODE_STEP_DOWN;
								nx.phase   = '0;
								nx.rpt     = '0;
								nx.blinks  = '0;
								nx.level   = ph_start.level;
								nx.ms_left = ph_start.dur;
							end else begin
								nx.level = '0;
								nx.off   = 1'b1;
							end
							nx.low_cnt = '0;
							nx.hold    = HOLD_MS;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/flashlight_mode_pattern_controller_top.sv -----
// Top level of the flashlight mode and pattern controller.
// Holds the config registers, state, input stage and result register.
// Depends on fmpc_pkg and fmpc_step.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | fmpc_req_t: command, short_press, adc_value
//  rsp     | out       | rsp_valid/rsp_stall  | fmpc_rsp_t: pwm_level, phase_correct, ...
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_wdata
//
// One transaction per cycle while the result side does not stall; a request passes
// the input stage, then the state update and result register in one pass.
// Reset clears state to mode 0, level 0 and loads the threshold defaults.
// A stalled result holds the input stage, which then stalls the request side.
// cfg_ready is always high.
module flashlight_mode_pattern_controller_top import fmpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  fmpc_req_t            req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output fmpc_rsp_t            rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata
);

	fmpc_cfg_t   cfg_q;
	fmpc_state_t state_q;
	fmpc_state_t state_nx;
	fmpc_req_t   req_s1;
	logic        vld_s1;
	logic        adv;
	logic        rsp_valid_q;
	fmpc_rsp_t   rsp_data_q;

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = vld_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_TH:    cfg_q.low_th   <= cfg_wdata;
				REG_CRIT_TH:   cfg_q.crit_th  <= cfg_wdata;
				REG_GAUGE_0:   cfg_q.gauge[0] <= cfg_wdata;
				REG_GAUGE_25:  cfg_q.gauge[1] <= cfg_wdata;
				REG_GAUGE_50:  cfg_q.gauge[2] <= cfg_wdata;
				REG_GAUGE_75:  cfg_q.gauge[3] <= cfg_wdata;
				REG_GAUGE_100: cfg_q.gauge[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_s1 <= req_data;
	end

	fmpc_step u_step (
		.st  (state_q),
		.cfg (cfg_q),
		.req (req_s1),
		.nx  (state_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_data_q.pwm_level     <= state_nx.level;
			rsp_data_q.phase_correct <= state_nx.pc;
			rsp_data_q.mode_index    <= state_nx.mode;
			rsp_data_q.powered_off   <= state_nx.off;
		end
	end

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.powered_off |-> rsp_data.pwm_level == '0)
		else $error("powered off with light on");

	a_pc_mode0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.phase_correct |-> rsp_data.mode_index == '0)
		else $error("phase-correct outside mode 0");

	a_low_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.low_cnt < LOW_LIMIT)
		else $error("low reading count not cleared");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(req_s1))
		else $error("input stage lost a stalled transaction");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for flashlight_mode_pattern_controller_top: directed and random event streams,
// checked against an in-bench model of modes, patterns, low-battery step-down and config.
// Depends on fmpc_pkg and the RTL under rtl/.
module tb_top import fmpc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [14:0][7:0] LAMP_LEVELS = {
		8'd37, 8'd255, 8'd255, 8'd15, 8'd41, 8'd82, 8'd255, 8'd37,
		8'd14, 8'd4, 8'd255, 8'd110, 8'd37, 8'd14, 8'd4
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	fmpc_req_t            req_data;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	fmpc_rsp_t            rsp_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;

	bit          steady = 1'b0;
	int unsigned mismatch_count = 0;
	fmpc_rsp_t   expected_light[$];

	// model state
	logic [3:0]       lamp_mode, stored_mode;
	logic [1:0]       step_idx;
	logic [10:0]      step_ms;
	logic [6:0]       cycle_cnt;
	logic [2:0]       low_run, blinks_left;
	logic [7:0]       batt_volt, lamp_level;
	logic [9:0]       hold_ms;
	logic             lamp_pc, lamp_off;
	logic [7:0]       low_level, crit_level;
	logic [4:0][7:0]  gauge_th;

	flashlight_mode_pattern_controller_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void reset_model();
		lamp_mode   = '0;
		stored_mode = '0;
		step_idx    = '0;
		step_ms     = '0;
		cycle_cnt   = '0;
		low_run     = '0;
		blinks_left = '0;
		batt_volt   = '0;
		lamp_level  = '0;
		hold_ms     = '0;
		lamp_pc     = 1'b0;
		lamp_off    = 1'b0;
		low_level   = CFG_RESET.low_th;
		crit_level  = CFG_RESET.crit_th;
		gauge_th    = CFG_RESET.gauge;
	endfunction

	// level and length of the current pattern step
	function automatic void enter_step();
		logic [6:0] s;
		lamp_level = 8'd0;
		step_ms    = 11'd1;
		if (lamp_mode >= MODE_BEACON_FIRST && lamp_mode <= MODE_BEACON_LAST) begin
			if (step_idx == 2'd0) begin
				lamp_level = LAMP_LEVELS[lamp_mode - 4'd3];
				step_ms    = 11'd5;
			end else begin
				lamp_level = LAMP_LEVELS[lamp_mode];
				step_ms    = (cycle_cnt >= 7'd3) ? 11'd785 : 11'd65;
			end
		end else if (lamp_mode == MODE_HEART) begin
			if (!step_idx[0]) lamp_level = LEVEL_MAX;
			else step_ms = (step_idx == 2'd1) ? 11'd249 : 11'd749;
		end else if (lamp_mode >= MODE_STROBE_FIRST && lamp_mode <= MODE_STROBE_LAST) begin
			if (step_idx == 2'd0) lamp_level = LEVEL_MAX;
			else step_ms = 11'(LAMP_LEVELS[lamp_mode]);
		end else if (lamp_mode == MODE_SWEEP_A) begin
			if (step_idx == 2'd0) begin
				lamp_level = LEVEL_MAX;
			end else begin
				s       = (cycle_cnt < 7'd33) ? cycle_cnt : 7'd66 - cycle_cnt;
				step_ms = 11'(s) * 11'd2 + 11'd54;
			end
		end else if (lamp_mode == MODE_SWEEP_B) begin
			if (step_idx == 2'd0) begin
				lamp_level = LEVEL_MAX;
			end else begin
				s       = (cycle_cnt < 7'd50) ? cycle_cnt : 7'd100 - cycle_cnt;
				step_ms = 11'(s) + 11'd9;
			end
		end else if (lamp_mode == MODE_GAUGE) begin
			if (step_idx == 2'd1) begin
				lamp_level = LEVEL_MED;
				step_ms    = 11'd100;
			end else begin
				step_ms = (step_idx == 2'd2) ? 11'd400 : 11'd1000;
			end
		end else begin
			lamp_level = LAMP_LEVELS[lamp_mode];
			step_ms    = 11'd0;
		end
	endfunction

	function automatic void restart_pattern();
		step_idx    = '0;
		cycle_cnt   = '0;
		blinks_left = '0;
		enter_step();
	endfunction

	function automatic logic [2:0] count_gauge_blinks();
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < GAUGES; i++)
			if (batt_volt > gauge_th[i]) n++;
		return n;
	endfunction

	function automatic void next_step();
		if (lamp_mode >= MODE_BEACON_FIRST && lamp_mode <= MODE_BEACON_LAST) begin
			if (step_idx == 2'd0) begin
				step_idx = 2'd1;
			end else begin
				cycle_cnt = (cycle_cnt >= 7'd3) ? 7'd0 : cycle_cnt + 7'd1;
				step_idx  = 2'd0;
			end
		end else if (lamp_mode == MODE_HEART) begin
			step_idx = step_idx + 2'd1;
		end else if (lamp_mode >= MODE_STROBE_FIRST && lamp_mode <= MODE_STROBE_LAST) begin
			step_idx = (step_idx == 2'd0) ? 2'd1 : 2'd0;
		end else if (lamp_mode == MODE_SWEEP_A || lamp_mode == MODE_SWEEP_B) begin
			if (step_idx == 2'd0) begin
				step_idx = 2'd1;
			end else begin
				if (cycle_cnt >= ((lamp_mode == MODE_SWEEP_A) ? 7'd65 : 7'd99)) cycle_cnt = 7'd0;
				else cycle_cnt = cycle_cnt + 7'd1;
				step_idx = 2'd0;
			end
		end else if (lamp_mode == MODE_GAUGE) begin
			case (step_idx)
				2'd0: begin
					blinks_left = count_gauge_blinks();
					step_idx    = (blinks_left != 0) ? 2'd1 : 2'd3;
				end
				2'd1: step_idx = 2'd2;
				2'd2: begin
					if (blinks_left != 0) blinks_left--;
					step_idx = (blinks_left != 0) ? 2'd1 : 2'd3;
				end
				default: step_idx = 2'd0;
			endcase
		end else begin
			return;
		end
		enter_step();
	endfunction

	function automatic fmpc_rsp_t predict_light(input fmpc_req_t item);
		fmpc_rsp_t  r;
		logic [7:0] th;
		case (item.command)
			CMD_BOOT: begin
				if (item.short_press)
					stored_mode = (stored_mode >= MODE_LAST) ? 4'd0 : stored_mode + 4'd1;
				else
					stored_mode = 4'd0;
				lamp_mode = stored_mode;
				lamp_pc   = (lamp_mode == 4'd0);
				lamp_off  = 1'b0;
				low_run   = '0;
				hold_ms   = '0;
				restart_pattern();
			end
			CMD_TICK: begin
				if (!lamp_off) begin
					if (hold_ms != 0) hold_ms--;
					if (lamp_mode > MODE_SOLID_LAST) begin
						if (step_ms > 11'd1) step_ms--;
						else next_step();
					end
				end
			end
			CMD_ADC: begin
				if (!lamp_off) begin
					batt_volt = item.adc_value;
					if (hold_ms == 0) begin
						th = (lamp_mode == 4'd0) ? crit_level : low_level;
						if (item.adc_value < th) low_run++;
						else low_run = '0;
						if (low_run >= LOW_LIMIT) begin
							if (lamp_mode > MODE_STEP_DOWN) begin
								lamp_mode = MODE_STEP_DOWN;
								restart_pattern();
							end else begin
								lamp_level = 8'd0;
								lamp_off   = 1'b1;
							end
							low_run = '0;
							hold_ms = HOLD_MS;
						end
					end
				end
			end
			default: ;
		endcase
		r.pwm_level     = lamp_level;
		r.phase_correct = lamp_pc;
		r.mode_index    = lamp_mode;
		r.powered_off   = lamp_off;
		return r;
	endfunction

	function automatic fmpc_req_t make_event(input logic [1:0] cmd, input logic sp,
			input logic [7:0] adc);
		fmpc_req_t e;
		e.command     = cmd;
		e.short_press = sp;
		e.adc_value   = adc;
		return e;
	endfunction

	task automatic send_event(input fmpc_req_t item);
		while (!steady && $urandom_range(0, 99) < 29) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_light.push_back(predict_light(item));
	endtask

	task automatic send_boot(input logic sp);
		send_event(make_event(CMD_BOOT, sp, 8'($urandom_range(0, 255))));
	endtask

	task automatic send_adc(input logic [7:0] v);
		send_event(make_event(CMD_ADC, 1'b0, v));
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_event(make_event(CMD_TICK, 1'b0, 8'd0));
	endtask

	task automatic wait_all_results();
		req_valid <= 1'b0;
		while (expected_light.size() != 0) @(posedge clk);
	endtask

	task automatic put_register(input fmpc_reg_t idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_LOW_TH:  low_level  = value;
			REG_CRIT_TH: crit_level = value;
			default:     gauge_th[idx - REG_GAUGE_0] = value;
		endcase
	endtask

	task automatic load_settings(input logic [7:0] low, input logic [7:0] crit,
			input logic [4:0][7:0] levels);
		wait_all_results();
		put_register(REG_LOW_TH, low);
		put_register(REG_CRIT_TH, crit);
		put_register(REG_GAUGE_0, levels[0]);
		put_register(REG_GAUGE_25, levels[1]);
		put_register(REG_GAUGE_50, levels[2]);
		put_register(REG_GAUGE_75, levels[3]);
		put_register(REG_GAUGE_100, levels[4]);
		cfg_valid <= 1'b0;
	endtask

	// events before the first boot, then a walk through every mode and the wrap
	task automatic test_power_up();
		send_ticks(1);
		send_event(make_event(CMD_NONE, 1'b1, 8'hA5));
		send_adc(8'd255);
		send_adc(8'd0);
		send_boot(1'b0);
		repeat (15) send_boot(1'b1);
		send_ticks(2);
		send_boot(1'b1);
		send_boot(1'b0);
	endtask

	// step-down to mode 1, hold window, then shutdown from mode 1 and from mode 0
	task automatic test_step_down();
		send_boot(1'b0);
		send_boot(1'b1);
		send_boot(1'b1);
		send_adc(8'd122);
		send_adc(8'd0);
		send_adc(8'd50);
		send_adc(8'd100);
		send_adc(8'd0);
		send_adc(8'd255);
		wait_all_results();
		send_ticks(5);
		repeat (4) send_adc(8'd0);
		send_boot(1'b0);
		send_boot(1'b1);
		repeat (3) send_adc(8'd122);
		send_adc(8'd123);
		repeat (4) send_adc(8'd0);
		send_ticks(1);
		send_adc(8'd0);
		send_event(make_event(CMD_NONE, 1'b0, 8'd0));
		send_boot(1'b1);
		send_boot(1'b0);
		repeat (4) send_adc(8'd112);
		send_ticks(1);
		send_boot(1'b0);
	endtask

	// gauge: one blink, then the gap and into the closing dark phase
	task automatic test_gauge();
		send_boot(1'b0);
		repeat (14) send_boot(1'b1);
		send_adc(8'd150);
		send_ticks(1502);
	endtask

	task automatic test_random_mix(input int unsigned quota);
		int unsigned sent, burst, roll, target;
		bit          draining;
		logic [7:0]  th, v;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 7) == 0) wait_all_results();
			target = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0) begin
				send_boot(1'b1);
				sent++;
			end else begin
				send_boot(1'b0);
				repeat (target) send_boot(1'b1);
				sent += target + 1;
			end
			draining = ($urandom_range(0, 2) == 0);
			burst    = $urandom_range(10, 60);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < 78) begin
					send_event(make_event(CMD_TICK, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255))));
				end else if (roll < 94) begin
					th = (lamp_mode == 4'd0) ? crit_level : low_level;
					if (draining && th != 0) v = 8'($urandom_range(0, th - 1));
					else v = 8'($urandom_range(0, 255));
					send_event(make_event(CMD_ADC, 1'($urandom_range(0, 1)), v));
				end else if (roll < 97) begin
					send_boot(1'($urandom_range(0, 1)));
				end else begin
					send_event(make_event(CMD_NONE, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255))));
				end
			end
			sent += burst;
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// result side: random stall unless steady, one check per transaction
	always @(posedge clk) begin : light_check
		fmpc_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_light.size() == 0) begin
				$error("result transaction with no request pending");
				mismatch_count++;
			end else begin
				want = expected_light.pop_front();
				compare_field("pwm_level", want.pwm_level, rsp_data.pwm_level);
				compare_field("phase_correct", 8'(want.phase_correct), 8'(rsp_data.phase_correct));
				compare_field("mode_index", 8'(want.mode_index), 8'(rsp_data.mode_index));
				compare_field("powered_off", 8'(want.powered_off), 8'(rsp_data.powered_off));
			end
		end
		rsp_stall <= !steady && ($urandom_range(0, 99) < 29);
	end

	initial begin
		logic [4:0][7:0] levels;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up();
		test_step_down();
		test_gauge();

		load_settings(8'd0, 8'd0, {5{8'd0}});
		test_random_mix(40);

		load_settings(8'd255, 8'd255, {5{8'd255}});
		steady <= 1'b1;
		test_random_mix(120);
		wait_all_results();
		steady <= 1'b0;

		for (int i = 0; i < GAUGES; i++) levels[i] = 8'($urandom_range(0, 255));
		load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), levels);
		test_random_mix(40);

		load_settings(CFG_RESET.low_th, CFG_RESET.crit_th, CFG_RESET.gauge);
		test_random_mix(40);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_light.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
